>>> rtl/crf_pkg.sv
// crf_pkg: shared types, codes and the crc-32 byte update for the record framer
// no dependencies; imported by crf_seq_crc and crc_record_framer
`default_nettype none

package crf_pkg;

    // framing constants
    localparam int unsigned MaxPacket   = 512;
    localparam int unsigned HeaderBytes = 12;
    localparam int unsigned MaxResults  = 10;

    localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
    localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam logic [1:0] RegEnable     = 2'd0;
    localparam logic [1:0] RegDeployment = 2'd1;
    localparam logic [1:0] RegSegLimit   = 2'd2;
    localparam logic [1:0] RegSyncEvery  = 2'd3;

    // input commands
    localparam logic CmdStart = 1'b0;
    localparam logic CmdData  = 1'b1;

    typedef enum logic [2:0] {
        KIND_LEN  = 3'd0,
        KIND_SEQ  = 3'd1,
        KIND_PAY  = 3'd2,
        KIND_CRC  = 3'd3,
        KIND_NONE = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_DISABLED  = 3'd1,
        ERR_TOO_LONG  = 3'd2,
        ERR_NO_RECORD = 3'd3,
        ERR_BUSY      = 3'd4
    } t_err;

    // one buffered result word
    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       opens;
        logic       sync;
        t_err       err;
    } t_res;

    // reflected crc-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/crc_record_framer.sv
// crc_record_framer: frames packets into archive records with length, sequence and crc-32
// depends on crf_pkg and crf_seq_crc
//
// usage
//   slave stream: tuser is the command (0 start, 1 data), tdata carries the
//   packet length and the payload byte. master stream: one framed byte per
//   word, tuser gives its kind, tlast marks the last word caused by one input
//   word. configuration goes in through a plain write port; the user must
//   write it only while idle, the block does not enforce this. an input word
//   waits in the input register until the sequence crc is ready and the
//   result buffer is empty or on its last word, then is decoded into the
//   buffer, which drains one word per cycle while the receiver is ready. a
//   data word gives one result word, a start six (ten for an empty record),
//   the last data word of a record five and a rejected word one.
// reset
//   registers return to their reset values and the sequence crc is worked
//   out over the four sequence bytes; no word is decoded until that is done,
//   though the input register may already take one word.
// stalls
//   while the receiver holds off, the buffer keeps its words and the input
//   register still takes one further word.
`default_nettype none

module crc_record_framer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    // slave stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // packet_length[15:0], data_byte[23:16]
    input  wire logic        s_axis_tuser,  // cmd
    // master stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // out_byte[7:0], opens_segment[8], sync_now[9],
                                            // error[12:10], dropped_count[44:13], zero pad
    output logic [2:0]       m_axis_tuser,  // byte_kind
    output logic             m_axis_tlast
);
    import crf_pkg::*;

    // configuration
    logic        r_enable;
    logic        r_dep;
    logic [31:0] r_limit;
    logic [15:0] r_sync_every;

    // block state
    logic [31:0] r_seq;
    logic [31:0] r_crc;
    logic [15:0] r_left;
    logic        r_in_record;
    logic        r_seg_open;
    logic [31:0] r_seg_bytes;
    logic [15:0] r_since;
    logic [31:0] r_drop;

    // input register
    logic        r_in_valid;
    logic        r_in_cmd;
    logic [15:0] r_in_len;
    logic [7:0]  r_in_byte;

    // result buffer, head at entry 0
    t_res        r_buf [MaxResults];
    logic [3:0]  r_cnt;

    // next values from the decode
    t_res        n_buf [MaxResults];
    logic [3:0]  n_cnt;
    logic [31:0] n_seq;
    logic [31:0] n_crc;
    logic [15:0] n_left;
    logic        n_in_record;
    logic        n_seg_open;
    logic [31:0] n_seg_bytes;
    logic [15:0] n_since;
    logic [31:0] n_drop;
    logic        n_kick;

    logic        w_in_fire;
    logic        w_out_fire;
    logic        w_load;
    logic        w_crc_busy;
    logic [31:0] w_seq_crc;

    assign w_out_fire = m_axis_tvalid && m_axis_tready;
    // decode when the seq crc is done and the buffer is empty or hands over its last word
    assign w_load = r_in_valid && !w_crc_busy
                    && (r_cnt == 4'd0 || (r_cnt == 4'd1 && w_out_fire));
    assign s_axis_tready = !r_in_valid || w_load;
    assign w_in_fire = s_axis_tvalid && s_axis_tready;

    crf_seq_crc u_seq_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_kick  (n_kick && w_load),
        .i_seq   (r_seq),
        .o_busy  (w_crc_busy),
        .o_crc   (w_seq_crc)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_dep        <= 1'b0;
            r_limit      <= 32'd65536;
            r_sync_every <= 16'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                RegEnable:     r_enable     <= i_cfg_data[0];
                RegDeployment: r_dep        <= i_cfg_data[0];
                RegSegLimit:   r_limit      <= i_cfg_data;
                RegSyncEvery:  r_sync_every <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_fire) begin
            r_in_valid <= 1'b1;
        end else if (w_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_in_cmd  <= s_axis_tuser;
            r_in_len  <= s_axis_tdata[15:0];
            r_in_byte <= s_axis_tdata[23:16];
        end
    end

    // decode of one word: state update and its burst of results
    always_comb begin
        logic [16:0] size;
        logic        close;
        logic        opens;
        logic [15:0] since_base;
        logic [15:0] since_inc;
        logic        sync;
        logic        finish;
        logic [31:0] fin_crc;
        logic [31:0] data_crc;
        logic [15:0] left_dec;

        for (int i = 0; i < MaxResults; i++) begin
            n_buf[i] = '{data: 8'd0, kind: KIND_NONE, opens: 1'b0, sync: 1'b0, err: ERR_OK};
        end
        n_cnt       = 4'd1;
        n_seq       = r_seq;
        n_crc       = r_crc;
        n_left      = r_left;
        n_in_record = r_in_record;
        n_seg_open  = r_seg_open;
        n_seg_bytes = r_seg_bytes;
        n_since     = r_since;
        n_drop      = r_drop;
        n_kick      = 1'b0;

        // segment fill check, compared without wrap
        size  = 17'd10 + {1'b0, r_in_len};
        close = r_seg_open
                && (({1'b0, r_seg_bytes} + {16'd0, size}) > {1'b0, r_limit});
        opens = !r_seg_open || close;

        data_crc = crc_byte(r_crc, r_in_byte);
        left_dec = r_left - 16'd1;
        finish   = 1'b0;
        fin_crc  = 32'd0;

        if (r_in_cmd == CmdStart) begin
            since_base = opens ? 16'd0 : r_since;
        end else begin
            since_base = r_since;
        end
        since_inc = since_base + 16'd1;
        sync      = r_dep || (since_inc >= r_sync_every);

        if (r_in_cmd == CmdStart) begin
            if (r_in_record || !r_enable || ({16'd0, r_in_len} > 32'(MaxPacket))) begin
                n_drop = r_drop + 32'd1;
                if (r_in_record) begin
                    n_buf[0].err = ERR_BUSY;
                end else if (!r_enable) begin
                    n_buf[0].err = ERR_DISABLED;
                end else begin
                    n_buf[0].err = ERR_TOO_LONG;
                end
            end else begin
                n_seg_open  = 1'b1;
                n_seg_bytes = (opens ? 32'(HeaderBytes) : r_seg_bytes) + {15'd0, size};
                n_since     = since_base;
                n_buf[0]    = '{data: r_in_len[15:8], kind: KIND_LEN, opens: opens,
                                sync: 1'b0, err: ERR_OK};
                n_buf[1]    = '{data: r_in_len[7:0], kind: KIND_LEN, opens: 1'b0,
                                sync: 1'b0, err: ERR_OK};
                for (int i = 0; i < 4; i++) begin
                    n_buf[2 + i] = '{data: r_seq[8 * (3 - i) +: 8], kind: KIND_SEQ,
                                     opens: 1'b0, sync: 1'b0, err: ERR_OK};
                end
                n_seq       = r_seq + 32'd1;
                n_kick      = 1'b1;
                n_crc       = w_seq_crc;
                n_left      = r_in_len;
                n_in_record = 1'b1;
                n_cnt       = 4'd6;
                if (r_in_len == 16'd0) begin
                    // empty record closes at once
                    finish  = 1'b1;
                    fin_crc = ~w_seq_crc;
                    for (int i = 0; i < 4; i++) begin
                        n_buf[6 + i] = '{data: fin_crc[8 * (3 - i) +: 8], kind: KIND_CRC,
                                         opens: 1'b0, sync: 1'b0, err: ERR_OK};
                    end
                    n_buf[9].sync = sync;
                    n_cnt         = 4'd10;
                end
            end
        end else begin
            if (!r_in_record) begin
                n_buf[0].err = ERR_NO_RECORD;
            end else begin
                n_crc    = data_crc;
                n_left   = left_dec;
                n_buf[0] = '{data: r_in_byte, kind: KIND_PAY, opens: 1'b0,
                             sync: 1'b0, err: ERR_OK};
                if (left_dec == 16'd0) begin
                    finish  = 1'b1;
                    fin_crc = ~data_crc;
                    for (int i = 0; i < 4; i++) begin
                        n_buf[1 + i] = '{data: fin_crc[8 * (3 - i) +: 8], kind: KIND_CRC,
                                         opens: 1'b0, sync: 1'b0, err: ERR_OK};
                    end
                    n_buf[4].sync = sync;
                    n_cnt         = 4'd5;
                end
            end
        end

        if (finish) begin
            n_since     = sync ? 16'd0 : since_inc;
            n_crc       = CrcInit;
            n_in_record = 1'b0;
        end
    end

    // state registers, updated when a word is decoded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= 32'd0;
            r_crc       <= CrcInit;
            r_left      <= 16'd0;
            r_in_record <= 1'b0;
            r_seg_open  <= 1'b0;
            r_seg_bytes <= 32'd0;
            r_since     <= 16'd0;
            r_drop      <= 32'd0;
        end else if (w_load) begin
            r_seq       <= n_seq;
            r_crc       <= n_crc;
            r_left      <= n_left;
            r_in_record <= n_in_record;
            r_seg_open  <= n_seg_open;
            r_seg_bytes <= n_seg_bytes;
            r_since     <= n_since;
            r_drop      <= n_drop;
        end
    end

    // result buffer count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 4'd0;
        end else if (w_load) begin
            r_cnt <= n_cnt;
        end else if (w_out_fire) begin
            r_cnt <= r_cnt - 4'd1;
        end
    end

    // result buffer payload, shifts towards the head
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            for (int i = 0; i < MaxResults; i++) begin
                r_buf[i] <= n_buf[i];
            end
        end else if (w_out_fire) begin
            for (int i = 0; i < MaxResults - 1; i++) begin
                r_buf[i] <= r_buf[i + 1];
            end
        end
    end

    // master stream; drop count follows the word whose burst is on show
    assign m_axis_tvalid = (r_cnt != 4'd0);
    assign m_axis_tlast  = (r_cnt == 4'd1);
    assign m_axis_tuser  = r_buf[0].kind;
    assign m_axis_tdata  = {3'd0, r_drop, r_buf[0].err, r_buf[0].sync,
                            r_buf[0].opens, r_buf[0].data};

    // sync only ever rides on the final crc word of a burst
    a_sync_on_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_buf[0].sync) |-> (r_buf[0].kind == KIND_CRC && m_axis_tlast))
        else $error("sync flag away from final crc word");

    // segment opening flagged only on a length word
    a_opens_on_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_buf[0].opens) |-> (r_buf[0].kind == KIND_LEN))
        else $error("segment open flag on a non-length word");

    // an open record always has payload still to come
    a_record_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_record |-> (r_left != 16'd0))
        else $error("record open with no bytes left");

    // a decode always leaves words in the result buffer
    a_load_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (r_cnt != 4'd0))
        else $error("decode left an empty result buffer");

endmodule

`default_nettype wire

>>> rtl/crf_seq_crc.sv
// crf_seq_crc: precomputes the crc over the four big-endian sequence bytes
// one byte per cycle, most significant first; uses crf_pkg
`default_nettype none

module crf_seq_crc (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_kick,
    input  wire logic [31:0] i_seq,
    output logic             o_busy,
    output logic [31:0]      o_crc
);
    import crf_pkg::*;

    logic        r_busy;
    logic [1:0]  r_idx;
    logic [31:0] r_acc;
    logic [7:0]  w_byte;

    // most significant byte first
    assign w_byte = i_seq[{~r_idx, 3'b000} +: 8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
            r_acc  <= CrcInit;
        end else if (i_kick) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
            r_acc  <= CrcInit;
        end else if (r_busy) begin
            r_acc <= crc_byte(r_acc, w_byte);
            r_idx <= r_idx + 2'd1;
            if (r_idx == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_crc  = r_acc;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// testbench: self-checking bench for crc_record_framer, record framing and crc-32 trailer
// depends on crf_pkg for codes, kinds and framing constants, and on the framer rtl

module testbench;
    import crf_pkg::*;

    // one framed word as it leaves the master stream
    typedef struct packed {
        logic [7:0]  data;
        t_kind       kind;
        logic        opens;
        logic        sync;
        logic        last;
        t_err        err;
        logic [31:0] dropped;
    } t_framed_word;

    // mirror of the framer: own copy of the registers and record state,
    // plus the words still owed by the block in arrival order
    class record_ledger;
        logic         enable;
        logic         deployment;
        logic [31:0]  seg_limit;
        logic [15:0]  sync_every;
        logic [31:0]  record_seq;
        logic [31:0]  crc;
        logic [31:0]  seg_bytes;
        logic [31:0]  drop_total;
        logic [15:0]  bytes_left;
        logic [15:0]  since_sync;
        logic         in_record;
        logic         seg_open;
        t_framed_word burst[$];
        t_framed_word owed_words[$];
        int           fails;

        function new();
            enable     = 1'b0;
            deployment = 1'b0;
            seg_limit  = 32'd65536;
            sync_every = 16'd16;
            record_seq = 32'd0;
            crc        = CrcInit;
            seg_bytes  = 32'd0;
            drop_total = 32'd0;
            bytes_left = 16'd0;
            since_sync = 16'd0;
            in_record  = 1'b0;
            seg_open   = 1'b0;
            fails      = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [31:0] val);
            case (idx)
                RegEnable:     enable     = val[0];
                RegDeployment: deployment = val[0];
                RegSegLimit:   seg_limit  = val;
                RegSyncEvery:  sync_every = val[15:0];
                default:       ;
            endcase
        endfunction

        // reflected crc-32, bit at a time, data bit folded into the feedback test
        function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
            logic [31:0] r;
            r = c;
            for (int i = 0; i < 8; i++) begin
                if (r[0] ^ b[i])
                    r = (r >> 1) ^ CrcPoly;
                else
                    r = r >> 1;
            end
            return r;
        endfunction

        function void add(logic [7:0] d, t_kind k, logic op, logic sy, t_err e);
            t_framed_word w;
            w.data    = d;
            w.kind    = k;
            w.opens   = op;
            w.sync    = sy;
            w.last    = 1'b0;
            w.err     = e;
            w.dropped = 32'd0;
            burst.push_back(w);
        endfunction

        // crc trailer, sync decision on the final byte
        function void close_record();
            logic [31:0] c;
            logic        due;
            c = ~crc;
            since_sync = since_sync + 16'd1;
            due = deployment || (since_sync >= sync_every);
            if (due)
                since_sync = 16'd0;
            add(c[31:24], KIND_CRC, 1'b0, 1'b0, ERR_OK);
            add(c[23:16], KIND_CRC, 1'b0, 1'b0, ERR_OK);
            add(c[15:8],  KIND_CRC, 1'b0, 1'b0, ERR_OK);
            add(c[7:0],   KIND_CRC, 1'b0, due,  ERR_OK);
            crc       = CrcInit;
            in_record = 1'b0;
        endfunction

        // segment bookkeeping, then length and sequence header
        function void open_record(logic [15:0] len);
            logic [32:0] size;
            logic        op;
            size = 33'd10 + len;
            op   = 1'b0;
            // full segment closes; a fresh one always takes its first record
            if (seg_open && ({1'b0, seg_bytes} + size > {1'b0, seg_limit})) begin
                seg_open   = 1'b0;
                since_sync = 16'd0;
            end
            if (!seg_open) begin
                seg_open   = 1'b1;
                seg_bytes  = HeaderBytes;
                since_sync = 16'd0;
                op         = 1'b1;
            end
            seg_bytes = seg_bytes + size[31:0];
            add(len[15:8], KIND_LEN, op,   1'b0, ERR_OK);
            add(len[7:0],  KIND_LEN, 1'b0, 1'b0, ERR_OK);
            crc = CrcInit;
            for (int i = 3; i >= 0; i--) begin
                crc = crc_step(crc, record_seq[8*i +: 8]);
                add(record_seq[8*i +: 8], KIND_SEQ, 1'b0, 1'b0, ERR_OK);
            end
            record_seq = record_seq + 32'd1;
            bytes_left = len;
            in_record  = 1'b1;
            if (len == 16'd0)
                close_record();
        endfunction

        // works out every word that one accepted input word causes
        function void take_input(logic cmd, logic [15:0] len, logic [7:0] b);
            t_framed_word w;
            burst.delete();
            if (cmd == CmdStart) begin
                if (in_record) begin
                    drop_total = drop_total + 32'd1;
                    add(8'd0, KIND_NONE, 1'b0, 1'b0, ERR_BUSY);
                end else if (!enable) begin
                    drop_total = drop_total + 32'd1;
                    add(8'd0, KIND_NONE, 1'b0, 1'b0, ERR_DISABLED);
                end else if (len > MaxPacket) begin
                    drop_total = drop_total + 32'd1;
                    add(8'd0, KIND_NONE, 1'b0, 1'b0, ERR_TOO_LONG);
                end else begin
                    open_record(len);
                end
            end else if (!in_record) begin
                add(8'd0, KIND_NONE, 1'b0, 1'b0, ERR_NO_RECORD);
            end else begin
                crc = crc_step(crc, b);
                add(b, KIND_PAY, 1'b0, 1'b0, ERR_OK);
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 16'd0)
                    close_record();
            end
            for (int k = 0; k < burst.size(); k++) begin
                w         = burst[k];
                w.dropped = drop_total;
                w.last    = (k == burst.size() - 1);
                owed_words.push_back(w);
            end
        endfunction

        task report(string what);
            if (fails < 200)
                $display("mismatch at %0t: %s", $time, what);
            fails++;
        endtask

        task match_output(t_framed_word got);
            t_framed_word want;
            if (owed_words.size() == 0) begin
                report($sformatf("word %h with none owed", got));
                return;
            end
            want = owed_words.pop_front();
            if (got.data !== want.data)
                report($sformatf("out_byte %h, want %h", got.data, want.data));
            if (got.kind !== want.kind)
                report($sformatf("byte_kind %0d, want %0d", got.kind, want.kind));
            if (got.opens !== want.opens)
                report($sformatf("opens_segment %b, want %b", got.opens, want.opens));
            if (got.sync !== want.sync)
                report($sformatf("sync_now %b, want %b", got.sync, want.sync));
            if (got.last !== want.last)
                report($sformatf("tlast %b, want %b", got.last, want.last));
            if (got.err !== want.err)
                report($sformatf("error %0d, want %0d", got.err, want.err));
            if (got.dropped !== want.dropped)
                report($sformatf("dropped_count %0d, want %0d", got.dropped, want.dropped));
        endtask
    endclass

    // clock and reset
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    // configuration port, quiet until written
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_idx  = RegEnable;
    logic [31:0] i_cfg_data = 32'd0;

    // slave stream into the framer
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = 24'd0;      // packet_length[15:0], data_byte[23:16]
    logic        s_axis_tuser  = CmdStart;   // cmd

    // master stream out of the framer
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;               // out_byte[7:0], opens_segment[8], sync_now[9],
                                             // error[12:10], dropped_count[44:13], zero pad
    logic [2:0]  m_axis_tuser;               // byte_kind
    logic        m_axis_tlast;

    // idling odds in percent, changed per phase
    int send_idle  = 0;
    int recv_stall = 0;
    int words_sent = 0;

    record_ledger book = new();

    crc_record_framer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // receiver: random back-pressure, changed on the falling edge only
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall);
    end

    // output monitor: every accepted word goes to the ledger
    always @(posedge i_clk) begin : watch_output
        t_framed_word got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.data    = m_axis_tdata[7:0];
            got.kind    = t_kind'(m_axis_tuser);
            got.opens   = m_axis_tdata[8];
            got.sync    = m_axis_tdata[9];
            got.last    = m_axis_tlast;
            got.err     = t_err'(m_axis_tdata[12:10]);
            got.dropped = m_axis_tdata[44:13];
            book.match_output(got);
        end
    end

    // offers one word, holds it until taken; returns on the next falling edge
    // with tvalid still high so back-to-back words need no second assignment
    task automatic send_word(logic cmd, logic [15:0] len, logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {b, len};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        book.take_input(cmd, len, b);
        words_sent++;
        @(negedge i_clk);
    endtask

    // well-formed record with random payload, the odd busy start slipped in
    task automatic send_record(logic [15:0] len);
        send_word(CmdStart, len, 8'($urandom_range(0, 255)));
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 4)
                send_word(CmdStart, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            send_word(CmdData, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
        end
    endtask

    // stream goes quiet until every owed word is back, then a margin for the pipeline
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (book.owed_words.size() != 0)
            @(negedge i_clk);
        repeat (12) @(negedge i_clk);
    endtask

    // all four registers in back-to-back cycles, only while the block is idle
    task automatic configure(logic en, logic dep, logic [31:0] lim, logic [15:0] sev);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= RegEnable;
        i_cfg_data <= {31'd0, en};
        @(negedge i_clk);
        i_cfg_idx  <= RegDeployment;
        i_cfg_data <= {31'd0, dep};
        @(negedge i_clk);
        i_cfg_idx  <= RegSegLimit;
        i_cfg_data <= lim;
        @(negedge i_clk);
        i_cfg_idx  <= RegSyncEvery;
        i_cfg_data <= {16'd0, sev};
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        book.set_register(RegEnable, {31'd0, en});
        book.set_register(RegDeployment, {31'd0, dep});
        book.set_register(RegSegLimit, lim);
        book.set_register(RegSyncEvery, {16'd0, sev});
    endtask

    // mostly whole records, some stray data and oversize starts as noise
    task automatic random_traffic(int n);
        int stop;
        int r;
        int len;
        stop = words_sent + n;
        while (words_sent < stop) begin
            r = $urandom_range(0, 99);
            if (r < 7) begin
                send_word(CmdData, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
            end else if (r < 13) begin
                if ($urandom_range(0, 3) == 0)
                    len = 65535;
                else
                    len = $urandom_range(MaxPacket + 1, 65535);
                send_word(CmdStart, 16'(len), 8'($urandom_range(0, 255)));
            end else begin
                // short payloads dominate, a few medium ones
                r = $urandom_range(0, 99);
                if (r < 70)
                    len = $urandom_range(0, 6);
                else if (r < 95)
                    len = $urandom_range(7, 40);
                else
                    len = $urandom_range(41, 120);
                send_record(16'(len));
            end
        end
    endtask

    task automatic run_phase(logic en, logic dep, logic [31:0] lim, logic [15:0] sev,
                             int idle, int stall, int n);
        configure(en, dep, lim, sev);
        send_idle  = idle;
        recv_stall = stall;
        random_traffic(n);
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // still disabled after reset: start dropped, data has no record
        send_word(CmdStart, 16'd5, 8'h3C);
        send_word(CmdData, 16'hFFFF, 8'hFF);

        // tiny segment, sync on every record through the zero setting
        configure(1'b1, 1'b0, 32'd20, 16'd0);
        send_word(CmdStart, 16'd0, 8'h00);          // empty record, fresh segment over limit
        send_word(CmdStart, 16'd0, 8'hFF);          // no room left, rolls over
        send_word(CmdStart, 16'hFFFF, 8'h00);       // far too long
        send_word(CmdStart, 16'(MaxPacket + 1), 8'h81);
        send_word(CmdStart, 16'd3, 8'h7E);
        send_word(CmdData, 16'h0000, 8'h00);
        send_word(CmdStart, 16'd2, 8'h11);          // busy, record carries on
        send_word(CmdData, 16'hFFFF, 8'hFF);
        send_word(CmdData, 16'h5A5A, 8'hA5);
        send_word(CmdData, 16'h0000, 8'h00);        // record already closed

        // deployment sync, segment never fills
        configure(1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        send_word(CmdStart, 16'd1, 8'h00);
        send_word(CmdData, 16'h1234, 8'h5A);
        send_word(CmdStart, 16'd2, 8'hC3);
        send_word(CmdData, 16'h8000, 8'h01);
        send_word(CmdData, 16'h0001, 8'h80);

        // no idling, zero limit: every record opens a segment; one longer record
        configure(1'b1, 1'b0, 32'd0, 16'd1);
        send_idle  = 0;
        recv_stall = 0;
        send_record(16'd48);
        random_traffic(50);

        run_phase(1'b1, 1'b0, 32'($urandom_range(40, 300)), 16'd3, 64, 0, 60);
        run_phase(1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 0, 64, 60);
        run_phase(1'b1, 1'b0, 32'($urandom_range(100, 600)), 16'd0, 14, 14, 60);
        run_phase(1'b0, 1'b0, 32'd0, 16'd1, 0, 0, 20);
        run_phase(1'b1, 1'b0, 32'd65536, 16'd16, 14, 14, 50);

        settle();
        if (book.fails == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #4000000;
        $display("testbench failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/crf_pkg.sv
rtl/crf_seq_crc.sv
rtl/crc_record_framer.sv
tb/testbench.sv
